// ===== hw/rtl/isr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isr_pkg
// Beat types and command and status codes shared by the indexed stack.
// ----------------------------------------------------------------------------
package isr_pkg;

    // Command codes carried in the op field.
    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  index;
        logic [31:0] value;
    } t_in;

    typedef struct packed {
        logic [31:0] read_value;
        logic [7:0]  count;
        logic        is_empty;
        logic [1:0]  status;
    } t_out;

endpackage
`default_nettype wire

// ===== hw/rtl/isr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module isr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_stack_with_remove.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_stack_with_remove
// Bounded list of words with push, pop, indexed read, indexed remove and
// clear, one result beat per command beat.
// ----------------------------------------------------------------------------
// The block keeps up to DEPTH words in one simple dual-port RAM (one write
// port, one read port with registered read data) and the entry count in a
// register. It works on one command at a time and takes a new command
// beat only while it is idle and its output register is free or being
// drained. Push, clear, refused commands and unused op codes finish in the
// cycle they are accepted, so their result beat is offered on the next
// cycle. Pop and read need one RAM read; the result beat is built in
// S_READ. Remove reads the removed word the same way, then moves every
// entry above it down in S_SHIFT, as the RAM read port delivers one entry
// per cycle while the write port stores it one place lower; its result
// beat is offered as soon as the removed word has been read, while the
// shift is still running. Every result beat carries the count after the
// command, an empty flag and a status. Words wider than 32 bits are
// truncated on the result, and a pushed word is kept in its low WORD_WIDTH
// bits. The RAM needs no clearing after reset: only entries below the
// count are ever read, and those have always been written.
// ----------------------------------------------------------------------------
module indexed_stack_with_remove #(
    parameter int DEPTH      = 128,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire isr_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output isr_pkg::t_out      o_out_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam int XW   = (CW > 8) ? CW : 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic               r_remove, n_remove;
    logic               r_out_valid, n_out_valid;
    isr_pkg::t_out      r_out, n_out;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [WORD_WIDTH-1:0] mem_rdata;

    logic               out_free;
    logic               in_take;
    logic               is_full;
    logic               idx_ok;
    logic [CMPW-1:0]    idx_ext;
    logic [CW-1:0]      count_m1;
    logic [CW-1:0]      count_p1;
    logic [AW-1:0]      ptr_p1;
    logic [CW-1:0]      ptr_p1_ext;
    logic [WORD_WIDTH-1:0] push_word;
    logic [31:0]        rd_word;
    logic [XW-1:0]      count_wide;
    logic [XW-1:0]      count_p1_wide;

    isr_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The output register is free when empty or when its beat leaves now.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_take    = i_in_valid && !o_in_stall;

    assign is_full       = (r_count == CW'(DEPTH));
    assign idx_ext       = CMPW'(i_in_data.index);
    assign idx_ok        = (idx_ext < CMPW'(r_count));
    assign count_m1      = r_count - CW'(1);
    assign count_p1      = r_count + CW'(1);
    assign ptr_p1        = r_ptr + AW'(1);
    assign ptr_p1_ext    = CW'(r_ptr) + CW'(1);
    assign push_word     = WORD_WIDTH'(64'(i_in_data.value));
    assign rd_word       = 32'(64'(mem_rdata));
    assign count_wide    = XW'(r_count);
    assign count_p1_wide = XW'(count_p1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_remove    = r_remove;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_count[AW-1:0];
        mem_wdata   = push_word;
        mem_raddr   = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    // Default result: nothing read, state unchanged.
                    n_out.read_value = '0;
                    n_out.count      = count_wide[7:0];
                    n_out.is_empty   = (r_count == '0);
                    n_out.status     = isr_pkg::ST_OK;
                    n_out_valid      = 1'b1;
                    case (i_in_data.op)
                        isr_pkg::OP_PUSH: begin
                            if (is_full) begin
                                n_out.status = isr_pkg::ST_FULL;
                            end else begin
                                mem_we         = 1'b1;
                                n_count        = count_p1;
                                n_out.count    = count_p1_wide[7:0];
                                n_out.is_empty = 1'b0;
                            end
                        end
                        isr_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_out.status = isr_pkg::ST_EMPTY;
                            end else begin
                                // The last entry sits at the new count.
                                n_count     = count_m1;
                                mem_raddr   = count_m1[AW-1:0];
                                n_remove    = 1'b0;
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        isr_pkg::OP_READ, isr_pkg::OP_REMOVE: begin
                            if (!idx_ok) begin
                                n_out.status = isr_pkg::ST_RANGE;
                            end else begin
                                mem_raddr   = idx_ext[AW-1:0];
                                n_ptr       = idx_ext[AW-1:0];
                                n_remove    = (i_in_data.op == isr_pkg::OP_REMOVE);
                                if (i_in_data.op == isr_pkg::OP_REMOVE) begin
                                    n_count = count_m1;
                                end
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        isr_pkg::OP_CLEAR: begin
                            n_count        = '0;
                            n_out.count    = '0;
                            n_out.is_empty = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_READ: begin
                // Read data is here; the count already holds its new value.
                n_out_valid      = 1'b1;
                n_out.read_value = rd_word;
                n_out.count      = count_wide[7:0];
                n_out.is_empty   = (r_count == '0);
                n_out.status     = isr_pkg::ST_OK;
                if (r_remove && (CW'(r_ptr) < r_count)) begin
                    // Start closing the gap: fetch the entry above it.
                    mem_raddr = ptr_p1;
                    n_state   = S_SHIFT;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_SHIFT: begin
                // Store the fetched entry one place lower and fetch the next.
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = mem_rdata;
                if (ptr_p1_ext < r_count) begin
                    mem_raddr = ptr_p1 + AW'(1);
                    n_ptr     = ptr_p1;
                end else begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_remove    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_remove    <= n_remove;
        end
        r_ptr <= n_ptr;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
